// ===== design/stk_pkg.sv =====
// ----------------------------------------------------------------------------
// stk_pkg
// Shared widths, request codes and control structs of the sorted score table.
// ----------------------------------------------------------------------------
package stk_pkg;

  localparam int REQ_W   = 2;
  localparam int SLOT_W  = 5;
  localparam int TAG_W   = 16;
  localparam int SCORE_W = 32;
  localparam int RANK_W  = 5;

  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SUBMIT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  // configuration register addresses
  localparam logic [1:0] CFG_ADDR_ORDER_MODE = 2'd0;

  // read address select
  localparam logic [1:0] RD_SLOT  = 2'd0;
  localparam logic [1:0] RD_LAST  = 2'd1;
  localparam logic [1:0] RD_PREV  = 2'd2;
  localparam logic [1:0] RD_PREV2 = 2'd3;

  typedef struct packed {
    logic       latch_in;
    logic       wr_load;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       shift;
    logic       put;
    logic       res_read;
    logic       out_load;
  } stk_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             slot_ok;
    logic             beats;
    logic             pos_zero;
    logic             pos_one;
    logic             out_free;
  } stk_sts_t;

endpackage

// ===== design/stk_in_if.sv =====
// ----------------------------------------------------------------------------
// stk_in_if
// Request channel: valid/ready handshake with one request word.
// ----------------------------------------------------------------------------
interface stk_in_if import stk_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [SLOT_W-1:0]  slot_index;
  logic [TAG_W-1:0]   player_tag;
  logic [SCORE_W-1:0] score_value;

  modport source (output valid, output req_type, output slot_index,
                  output player_tag, output score_value, input ready);
  modport sink   (input valid, input req_type, input slot_index,
                  input player_tag, input score_value, output ready);

endinterface

// ===== design/stk_out_if.sv =====
// ----------------------------------------------------------------------------
// stk_out_if
// Result channel: valid/ready handshake with one result word.
// ----------------------------------------------------------------------------
interface stk_out_if import stk_pkg::*; ();

  logic               valid;
  logic               ready;
  logic               qualified;
  logic [RANK_W-1:0]  rank;
  logic [TAG_W-1:0]   entry_tag;
  logic [SCORE_W-1:0] entry_score;

  modport source (output valid, output qualified, output rank,
                  output entry_tag, output entry_score, input ready);
  modport sink   (input valid, input qualified, input rank,
                  input entry_tag, input entry_score, output ready);

endinterface

// ===== design/stk_ctrl.sv =====
// ----------------------------------------------------------------------------
// stk_ctrl
// Sequencer for load, read and sorted insertion; drives the datapath.
// ----------------------------------------------------------------------------
module stk_ctrl import stk_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  stk_sts_t sts,
  output stk_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_LAST   = 3'd3;
  localparam logic [2:0] S_WALK   = 3'd4;
  localparam logic [2:0] S_PUT    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.req)
          REQ_LOAD: begin
            cmd.wr_load = sts.slot_ok;
            state_nxt   = S_DONE;
          end
          REQ_SUBMIT: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_LAST;
            state_nxt  = S_LAST;
          end
          REQ_READ: begin
            if (sts.slot_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_SLOT;
              state_nxt  = S_RDWAIT;
            end else begin
              state_nxt = S_DONE;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_RDWAIT: begin
        cmd.res_read = 1'b1;
        state_nxt    = S_DONE;
      end
      S_LAST: begin
        // last entry must be strictly beaten to qualify
        if (!sts.beats) begin
          state_nxt = S_DONE;
        end else if (sts.pos_zero) begin
          state_nxt = S_PUT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_nxt  = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.beats) begin
          // move the neighbour down one slot and keep climbing
          cmd.shift = 1'b1;
          if (sts.pos_one) begin
            state_nxt = S_PUT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_PREV2;
          end
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/stk_dp.sv =====
// ----------------------------------------------------------------------------
// stk_dp
// Table memory, request registers, comparator and output register.
// ----------------------------------------------------------------------------
module stk_dp import stk_pkg::*; #(
  parameter int LIST_SIZE = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               order_mode,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [SLOT_W-1:0]  in_slot_index,
  input  logic [TAG_W-1:0]   in_player_tag,
  input  logic [SCORE_W-1:0] in_score_value,
  input  stk_cmd_t           cmd,
  output stk_sts_t           sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_qualified,
  output logic [RANK_W-1:0]  out_rank,
  output logic [TAG_W-1:0]   out_entry_tag,
  output logic [SCORE_W-1:0] out_entry_score
);

  localparam int IDX_W = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIST_SIZE - 1);

  logic [TAG_W-1:0]   tag_mem   [LIST_SIZE];
  logic [SCORE_W-1:0] score_mem [LIST_SIZE];
  logic [LIST_SIZE-1:0] valid_r;

  logic [REQ_W-1:0]   req_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [TAG_W-1:0]   tag_r;
  logic [SCORE_W-1:0] score_r;
  logic [IDX_W-1:0]   pos_r;

  logic [TAG_W-1:0]   rd_tag_r;
  logic [SCORE_W-1:0] rd_score_r;

  logic               res_qual_r;
  logic [RANK_W-1:0]  res_rank_r;
  logic [TAG_W-1:0]   res_tag_r;
  logic [SCORE_W-1:0] res_score_r;

  logic               out_valid_r;
  logic               out_qual_r;
  logic [RANK_W-1:0]  out_rank_r;
  logic [TAG_W-1:0]   out_tag_r;
  logic [SCORE_W-1:0] out_score_r;

  logic [IDX_W-1:0]   slot_idx;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [TAG_W-1:0]   wr_tag;
  logic [SCORE_W-1:0] wr_score;

  assign slot_idx = IDX_W'(slot_r);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_SLOT:  rd_addr = slot_idx;
      RD_LAST:  rd_addr = LAST_IDX;
      RD_PREV:  rd_addr = pos_r - IDX_W'(1);
      RD_PREV2: rd_addr = pos_r - IDX_W'(2);
      default:  rd_addr = slot_idx;
    endcase
  end

  assign wr_en    = cmd.wr_load | cmd.shift | cmd.put;
  assign wr_addr  = cmd.wr_load ? slot_idx : pos_r;
  assign wr_tag   = cmd.shift ? rd_tag_r : tag_r;
  assign wr_score = cmd.shift ? rd_score_r : score_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_addr]   <= wr_tag;
      score_mem[wr_addr] <= wr_score;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_tag_r   <= valid_r[rd_addr] ? tag_mem[rd_addr] : '0;
      rd_score_r <= valid_r[rd_addr] ? score_mem[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_r   <= in_req_type;
      slot_r  <= in_slot_index;
      tag_r   <= in_player_tag;
      score_r <= in_score_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      pos_r <= LAST_IDX;
    end else if (cmd.shift) begin
      pos_r <= pos_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      res_qual_r  <= 1'b0;
      res_rank_r  <= '0;
      res_tag_r   <= '0;
      res_score_r <= '0;
    end else begin
      if (cmd.res_read) begin
        res_tag_r   <= rd_tag_r;
        res_score_r <= rd_score_r;
      end
      if (cmd.put) begin
        res_qual_r <= 1'b1;
        res_rank_r <= RANK_W'({1'b0, pos_r} + (IDX_W + 1)'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_qual_r  <= res_qual_r;
      out_rank_r  <= res_rank_r;
      out_tag_r   <= res_tag_r;
      out_score_r <= res_score_r;
    end
  end

  assign sts.req      = req_r;
  assign sts.slot_ok  = (32'(slot_r) < LIST_SIZE);
  assign sts.beats    = order_mode ? (score_r < rd_score_r) : (score_r > rd_score_r);
  assign sts.pos_zero = (pos_r == '0);
  assign sts.pos_one  = (pos_r == IDX_W'(1));
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_qualified   = out_qual_r;
  assign out_rank        = out_rank_r;
  assign out_entry_tag   = out_tag_r;
  assign out_entry_score = out_score_r;

endmodule

// ===== design/sorted_top_k_score_table.sv =====
// ----------------------------------------------------------------------------
// sorted_top_k_score_table
// Sorted table of the best LIST_SIZE (score, tag) pairs with insertion.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch (valid/ready); every request gives one result word
// on out_ch. A load writes an entry by index, a read returns one, a submit
// inserts the pair if it strictly beats the last entry and reports its rank.
// order_mode, written over the APB port at address 0, picks highest-first (0)
// or lowest-first (1); write it only while no request is in flight.
// One request is handled at a time. A qualifying submit walks up the table,
// one neighbour per cycle, moving each entry it beats down one slot. in_ch
// is ready again the cycle after the result is loaded into the output
// register. Reset clears the table (all entries read as zero), order_mode
// and the output register. If out_ch stalls, the finished result is held
// and the next result waits until the output register is free.
// ----------------------------------------------------------------------------
module sorted_top_k_score_table import stk_pkg::*; #(
  parameter int LIST_SIZE = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  stk_in_if.sink      in_ch,
  stk_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic     order_mode_r;
  logic     cfg_wr;
  stk_cmd_t cmd;
  stk_sts_t sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = {31'd0, order_mode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_mode_r <= 1'b0;
    end else if (cfg_wr && (cfg_paddr == CFG_ADDR_ORDER_MODE)) begin
      order_mode_r <= cfg_pwdata[0];
    end
  end

  stk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stk_dp #(
    .LIST_SIZE (LIST_SIZE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .order_mode      (order_mode_r),
    .in_req_type     (in_ch.req_type),
    .in_slot_index   (in_ch.slot_index),
    .in_player_tag   (in_ch.player_tag),
    .in_score_value  (in_ch.score_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_qualified   (out_ch.qualified),
    .out_rank        (out_ch.rank),
    .out_entry_tag   (out_ch.entry_tag),
    .out_entry_score (out_ch.entry_score)
  );

endmodule

// ===== tb/sorted_top_k_score_table_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_top_k_score_table_tb
// Self-checking bench for the sorted score table.
// ----------------------------------------------------------------------------
// Loads, submits, reads and unused codes go in over the request channel. A
// shadow copy of the table ranks every accepted request word and queues the
// answer it expects. Each result word is checked field by field against the
// oldest queued answer. Directed words cover ties and the boundary entry in
// both orders, out-of-range slots in highest-first only. Random phases then
// refill the table with sorted runs and submit scores near the stored ones,
// under changing idle rates on both channels and one long output stall.
// ----------------------------------------------------------------------------
module sorted_top_k_score_table_tb;
  import stk_pkg::*;

  localparam int LIST_SIZE    = 20;
  localparam int IDX_W        = $clog2(LIST_SIZE);
  localparam int DRAIN_CYCLES = LIST_SIZE + 10;
  localparam int STALL_CYCLES = 400;
  localparam int QUIET_LIMIT  = 4000;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic               qualified;
    logic [RANK_W-1:0]  rank;
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] score;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  stk_in_if  in_ch ();
  stk_out_if out_ch ();

  sorted_top_k_score_table #(.LIST_SIZE(LIST_SIZE)) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow copy of the table and the order register
  logic [SCORE_W-1:0] board_score [LIST_SIZE];
  logic [TAG_W-1:0]   board_tag   [LIST_SIZE];
  logic               low_first;

  result_t expected_results [$];
  int      error_count  = 0;
  int      src_idle_pct;
  int      snk_idle_pct;
  int      stall_seq    = 0;
  int      stall_seen   = 0;
  int      hold_left    = 0;
  int      quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit outranks(input logic [SCORE_W-1:0] a,
                                  input logic [SCORE_W-1:0] b);
    return low_first ? (a < b) : (a > b);
  endfunction

  function automatic result_t predict_result(input logic [REQ_W-1:0]   req,
                                             input logic [SLOT_W-1:0]  slot,
                                             input logic [TAG_W-1:0]   tag,
                                             input logic [SCORE_W-1:0] score);
    result_t r;
    int      pos;
    r = '0;
    case (req)
      REQ_LOAD: begin
        if (slot < LIST_SIZE) begin
          board_score[slot] = score;
          board_tag[slot]   = tag;
        end
      end
      REQ_SUBMIT: begin
        if (outranks(score, board_score[LIST_SIZE-1])) begin
          pos = LIST_SIZE - 1;
          // climb past strictly beaten entries only, so ties stay below
          while (pos > 0 && outranks(score, board_score[IDX_W'(pos - 1)])) begin
            board_score[IDX_W'(pos)] = board_score[IDX_W'(pos - 1)];
            board_tag[IDX_W'(pos)]   = board_tag[IDX_W'(pos - 1)];
            pos--;
          end
          board_score[IDX_W'(pos)] = score;
          board_tag[IDX_W'(pos)]   = tag;
          r.qualified              = 1'b1;
          r.rank                   = RANK_W'(pos + 1);
        end
      end
      REQ_READ: begin
        if (slot < LIST_SIZE) begin
          r.tag   = board_tag[slot];
          r.score = board_score[slot];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got 0x%0h, want 0x%0h", what, got, want);
    error_count++;
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result word with nothing pending", 64'(out_ch.entry_score),
                      64'd0);
    end else begin
      want = expected_results.pop_front();
      if (out_ch.qualified !== want.qualified)
        report_mismatch("qualified", 64'(out_ch.qualified), 64'(want.qualified));
      if (out_ch.rank !== want.rank)
        report_mismatch("rank", 64'(out_ch.rank), 64'(want.rank));
      if (out_ch.entry_tag !== want.tag)
        report_mismatch("entry_tag", 64'(out_ch.entry_tag), 64'(want.tag));
      if (out_ch.entry_score !== want.score)
        report_mismatch("entry_score", 64'(out_ch.entry_score), 64'(want.score));
    end
  endtask

  // result side: check, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      check_result();
    if (stall_seq != stall_seen) begin
      stall_seen = stall_seq;
      hold_left  = STALL_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TIMEOUT after %0d quiet cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_request(input logic [REQ_W-1:0]   req,
                              input logic [SLOT_W-1:0]  slot,
                              input logic [TAG_W-1:0]   tag,
                              input logic [SCORE_W-1:0] score);
    result_t want;
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= req;
    in_ch.slot_index  <= slot;
    in_ch.player_tag  <= tag;
    in_ch.score_value <= score;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // word taken at this edge; keep valid up in case the next one follows
    want = predict_result(req, slot, tag, score);
    expected_results.push_back(want);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_order_mode(input logic mode);
    settle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_ORDER_MODE;
    cfg_pwdata  <= {31'b0, mode};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    low_first   = mode;
    // read back
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata !== {31'b0, mode})
      report_mismatch("order_mode read back", 64'(cfg_prdata), 64'(mode));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [SCORE_W-1:0] candidate_score();
    logic [SCORE_W-1:0] near;
    logic [SCORE_W-1:0] last;
    near = board_score[IDX_W'($urandom_range(LIST_SIZE-1))];
    last = board_score[LIST_SIZE-1];
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return $urandom_range(1000);
      2:       return near;
      3:       return $urandom_range(1) ? near + 1'b1 : near - 1'b1;
      4:       return $urandom_range(1) ? {SCORE_W{1'b0}} : {SCORE_W{1'b1}};
      default: return $urandom_range(1) ? last + 1'b1 : last - 1'b1;
    endcase
  endfunction

  task automatic random_request();
    int                 pick;
    logic [SLOT_W-1:0]  slot;
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] score;
    pick  = $urandom_range(99);
    slot  = SLOT_W'($urandom_range(LIST_SIZE-1));
    tag   = TAG_W'($urandom);
    score = $urandom_range(1) ? $urandom : $urandom_range(1000);
    if (pick < 45)
      send_request(REQ_SUBMIT, SLOT_W'($urandom), tag, candidate_score());
    else if (pick < 68)
      send_request(REQ_READ, slot, tag, score);
    else if (pick < 86)
      send_request(REQ_LOAD, slot, tag, score);
    else if (pick < 94)
      send_request($urandom_range(1) ? REQ_LOAD : REQ_READ,
                   SLOT_W'($urandom_range(31, LIST_SIZE)), tag, score);
    else
      send_request(REQ_UNUSED, SLOT_W'($urandom), tag, $urandom);
  endtask

  // refill every slot with a run already sorted in the current order
  task automatic load_sorted_board();
    logic [SCORE_W-1:0] vals [$];
    bit                 wide;
    wide = ($urandom_range(1) == 1);
    for (int i = 0; i < LIST_SIZE; i++)
      vals.push_back(wide ? $urandom : $urandom_range(300));
    if (low_first)
      vals.sort();
    else
      vals.rsort();
    for (int i = 0; i < LIST_SIZE; i++)
      send_request(REQ_LOAD, SLOT_W'(i), TAG_W'($urandom), vals[i]);
  endtask

  task automatic test_directed_highest_first();
    send_request(REQ_READ,   0,  16'h0000, 32'h0000_0000);
    send_request(REQ_READ,   19, 16'h0000, 32'h0000_0000);
    send_request(REQ_READ,   31, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(REQ_UNUSED, 31, 16'hFFFF, 32'hFFFF_FFFF);
    // tie with an all-zero table must not qualify
    send_request(REQ_SUBMIT, 0,  16'h0001, 32'h0000_0000);
    send_request(REQ_SUBMIT, 0,  16'hFFFF, 32'hFFFF_FFFF);
    send_request(REQ_SUBMIT, 0,  16'h0002, 32'd5);
    send_request(REQ_SUBMIT, 0,  16'h0003, 32'd5);
    send_request(REQ_LOAD,   20, 16'h1234, 32'd7);
    send_request(REQ_LOAD,   31, 16'h4321, 32'd9);
    send_request(REQ_LOAD,   19, 16'hABCD, 32'd100);
    send_request(REQ_SUBMIT, 0,  16'h0004, 32'd100);
    send_request(REQ_SUBMIT, 0,  16'h0005, 32'd101);
    send_request(REQ_LOAD,   0,  16'h0006, 32'd0);
    send_request(REQ_SUBMIT, 0,  16'h0007, 32'd1);
    send_request(REQ_READ,   0,  16'h0000, 32'd0);
    send_request(REQ_READ,   1,  16'h0000, 32'd0);
    send_request(REQ_READ,   4,  16'h0000, 32'd0);
    send_request(REQ_READ,   19, 16'h0000, 32'd0);
  endtask

  task automatic test_directed_lowest_first();
    send_request(REQ_SUBMIT, 0,  16'h1111, 32'hFFFF_FFFF);
    send_request(REQ_LOAD,   19, 16'h1111, 32'hFFFF_FFFF);
    send_request(REQ_SUBMIT, 0,  16'h2222, 32'hFFFF_FFFF);
    send_request(REQ_SUBMIT, 0,  16'hAAAA, 32'h0000_0000);
    send_request(REQ_READ,   18, 16'h0000, 32'd0);
    send_request(REQ_READ,   19, 16'h0000, 32'd0);
  endtask

  task automatic test_random_mix(input int n_words);
    int sent;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(7) == 0) begin
        load_sorted_board();
        sent += LIST_SIZE;
      end else begin
        random_request();
        sent++;
      end
    end
  endtask

  // hold the result side long enough that the input side backs up
  task automatic test_backpressure();
    stall_seq <= stall_seq + 1;
    for (int i = 0; i < 40; i++)
      random_request();
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_LOAD;
    in_ch.slot_index  <= '0;
    in_ch.player_tag  <= '0;
    in_ch.score_value <= '0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= '0;
    cfg_pwdata        <= '0;
    low_first    = 1'b0;
    for (int i = 0; i < LIST_SIZE; i++) begin
      board_score[IDX_W'(i)] = '0;
      board_tag[IDX_W'(i)]   = '0;
    end
    src_idle_pct = 31;
    snk_idle_pct = 73;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    write_order_mode(1'b0);
    test_directed_highest_first();
    write_order_mode(1'b1);
    test_directed_lowest_first();
    test_random_mix(210);

    write_order_mode(1'b0);
    src_idle_pct = 73;
    snk_idle_pct = 31;
    test_random_mix(210);

    write_order_mode(1'b1);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_backpressure();
    test_random_mix(120);
    write_order_mode(1'b0);
    test_random_mix(100);

    settle();
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sorted_top_k_score_table.f =====
design/stk_pkg.sv
design/stk_in_if.sv
design/stk_out_if.sv
design/stk_ctrl.sv
design/stk_dp.sv
design/sorted_top_k_score_table.sv
tb/sorted_top_k_score_table_tb.sv
